/* sv/ckbh_pkg.sv */
`default_nettype none

package ckbh_pkg;

  // Sizes of the edge window and the histogram.
  localparam int MAX_EDGE_LEN = 64;
  localparam int PREFIX_BASES = 8;
  localparam int COUNT_WIDTH  = 32;
  localparam int MIN_EDGE_LEN = (PREFIX_BASES > 8) ? PREFIX_BASES : 8;

  localparam int WIN_W       = 2 * MAX_EDGE_LEN;
  localparam int SH_W        = $clog2(WIN_W + 1);
  localparam int BKT_W       = 2 * PREFIX_BASES;
  localparam int NUM_BUCKETS = 1 << BKT_W;
  localparam int LEN_W       = 7;
  localparam int SEEN_W      = $clog2(MAX_EDGE_LEN + 1);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Depth of the queue between the two halves and of the result queue.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Configuration port.
  localparam int PADDR_W      = 3;
  localparam int REG_IDX_W    = 1;
  localparam logic [REG_IDX_W-1:0] REG_EDGE_LEN = 1'b0;
  localparam logic [LEN_W-1:0] EDGE_LEN_RESET = 7'd32;

  // Request kinds.
  localparam logic REQ_FEED = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [1:0]  base;
    logic        read_start;
    logic [15:0] bucket_sel;
  } item_t;

  typedef struct packed {
    logic        edge_valid;
    logic        rc_chosen;
    logic [15:0] bucket;
    logic [31:0] bucket_count;
  } result_t;

  // Classified transaction handed from the front to the back.
  typedef struct packed {
    logic             req_type;
    logic             edge_valid;
    logic             rc_chosen;
    logic [BKT_W-1:0] addr;
  } work_t;

endpackage

`default_nettype wire

/* sv/ckbh_ram.sv */
`default_nettype none

module ckbh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/ckbh_front.sv */
`default_nettype none

module ckbh_front import ckbh_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire item_t            item,
  output logic                  full,
  input  wire logic [LEN_W-1:0] len_eff,
  input  wire logic             clearing,
  output logic                  q_push,
  output work_t                 q_entry,
  input  wire logic             q_full
);

  logic [WIN_W-1:0]  fwd_win;
  logic [WIN_W-1:0]  rc_win;
  logic [SEEN_W-1:0] bases_seen;

  logic [WIN_W-1:0]  fwd_next;
  logic [WIN_W-1:0]  rc_next;
  logic [SEEN_W-1:0] seen_base;
  logic [SEEN_W-1:0] seen_next;
  logic [SH_W-1:0]   span;
  logic [SH_W-1:0]   sh;
  logic              accept;
  logic              advance;

  // Stage register between acceptance and classification.
  logic              s1_valid;
  logic              s1_req;
  logic              s1_full;
  logic [BKT_W-1:0]  s1_sel;
  logic [WIN_W-1:0]  s1_fwd;
  logic [WIN_W-1:0]  s1_rc;

  logic              use_rc;

  assign advance = !s1_valid || !q_full;
  assign full    = clearing || !advance;
  assign accept  = push && !full;

  // Shift the new base into both strands; the complement of a 2-bit code is its inverse.
  always_comb begin
    fwd_next  = {fwd_win[WIN_W-3:0], item.base};
    rc_next   = {~item.base, rc_win[WIN_W-1:2]};
    seen_base = item.read_start ? '0 : bases_seen;
    seen_next = (seen_base < SEEN_W'(MAX_EDGE_LEN)) ? seen_base + 1'b1 : seen_base;
    span      = {len_eff, 1'b0};
    sh        = SH_W'(WIN_W) - span;
  end

  // Window state is updated only by feed transactions.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_win    <= '0;
      rc_win     <= '0;
      bases_seen <= '0;
    end else if (accept && item.req_type == REQ_FEED) begin
      fwd_win    <= fwd_next;
      rc_win     <= rc_next;
      bases_seen <= seen_next;
    end
  end

  // Capture the edge left-aligned on both strands, with the bases beyond it cleared.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && accept) begin
      s1_req  <= item.req_type;
      s1_full <= (seen_next >= SEEN_W'(len_eff));
      s1_sel  <= item.bucket_sel[BKT_W-1:0];
      s1_fwd  <= fwd_next << sh;
      s1_rc   <= rc_next & ~({WIN_W{1'b1}} >> span);
    end
  end

  // Pick the canonical strand; ties go to the forward strand.
  assign use_rc = s1_rc < s1_fwd;

  always_comb begin
    q_push = s1_valid && !q_full;
    q_entry.req_type   = s1_req;
    q_entry.edge_valid = (s1_req == REQ_FEED) && s1_full;
    q_entry.rc_chosen  = (s1_req == REQ_FEED) && s1_full && use_rc;
    if (s1_req == REQ_READ) begin
      q_entry.addr = s1_sel;
    end else if (use_rc) begin
      q_entry.addr = s1_rc[WIN_W-1 -: BKT_W];
    end else begin
      q_entry.addr = s1_fwd[WIN_W-1 -: BKT_W];
    end
  end

endmodule

`default_nettype wire

/* sv/ckbh_mid_queue.sv */
`default_nettype none

module ckbh_mid_queue import ckbh_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire work_t wr_entry,
  output logic       full,
  input  wire logic  pop,
  output work_t      rd_entry,
  output logic       empty
);

  work_t              slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr;
  logic [Q_PTR_W-1:0] rptr;
  logic [Q_CNT_W-1:0] count;

  assign full     = (count == Q_CNT_W'(Q_DEPTH));
  assign empty    = (count == '0);
  assign rd_entry = slots[rptr];

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wr_entry;
    end
  end

endmodule

`default_nettype wire

/* sv/ckbh_back.sv */
`default_nettype none

module ckbh_back import ckbh_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire work_t q_entry,
  input  wire logic  q_empty,
  output logic       q_pop,
  output logic       clearing,
  output result_t    result,
  output logic       empty,
  input  wire logic  pop
);

  logic [BKT_W-1:0]       clr_addr;

  logic                   b1_valid;
  work_t                  b1_entry;
  logic                   b1_wr;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic [COUNT_WIDTH-1:0] cur;
  logic [COUNT_WIDTH-1:0] new_val;
  result_t                b1_res;

  logic                   last_wr_valid;
  logic [BKT_W-1:0]       last_wr_addr;
  logic [COUNT_WIDTH-1:0] last_wr_data;

  logic                   ram_we;
  logic [BKT_W-1:0]       ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;

  result_t                out_slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]     out_wptr;
  logic [Q_PTR_W-1:0]     out_rptr;
  logic [Q_CNT_W-1:0]     out_count;
  logic                   out_pop;

  // Clearing pass over the whole histogram after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == {BKT_W{1'b1}}) begin
        clearing <= 1'b0;
      end
    end
  end

  // Take a transaction only when the result queue has room for it and the one in flight.
  assign q_pop = !q_empty && !clearing &&
                 ((out_count + Q_CNT_W'(b1_valid)) < Q_CNT_W'(Q_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else begin
      b1_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_entry <= q_entry;
    end
  end

  // The previous cycle's write is not yet visible in the read data, so forward it.
  always_comb begin
    if (last_wr_valid && last_wr_addr == b1_entry.addr) begin
      cur = last_wr_data;
    end else begin
      cur = rd_data;
    end
  end

  // Read requests clear the bucket; counted edges add one, saturating.
  always_comb begin
    b1_wr   = b1_valid && (b1_entry.req_type == REQ_READ || b1_entry.edge_valid);
    new_val = '0;
    b1_res  = '0;
    if (b1_entry.req_type == REQ_READ) begin
      b1_res.bucket_count = 32'(cur);
    end else if (b1_entry.edge_valid) begin
      new_val           = (cur == COUNT_MAX) ? cur : cur + 1'b1;
      b1_res.edge_valid = 1'b1;
      b1_res.rc_chosen  = b1_entry.rc_chosen;
      b1_res.bucket     = 16'(b1_entry.addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_wr_valid <= 1'b0;
    end else begin
      last_wr_valid <= b1_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_wr) begin
      last_wr_addr <= b1_entry.addr;
      last_wr_data <= new_val;
    end
  end

  // Histogram store, shared between the clearing pass and the update path.
  always_comb begin
    ram_we    = clearing || b1_wr;
    ram_waddr = clearing ? clr_addr : b1_entry.addr;
    ram_wdata = clearing ? '0 : new_val;
  end

  ckbh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (q_pop),
    .raddr (q_entry.addr),
    .rdata (rd_data)
  );

  // Result queue towards the consumer.
  assign out_pop = pop && !empty;
  assign empty   = (out_count == '0);
  assign result  = out_slots[out_rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wptr  <= '0;
      out_rptr  <= '0;
      out_count <= '0;
    end else begin
      if (b1_valid) begin
        out_wptr <= out_wptr + 1'b1;
      end
      if (out_pop) begin
        out_rptr <= out_rptr + 1'b1;
      end
      if (b1_valid && !out_pop) begin
        out_count <= out_count + 1'b1;
      end else if (out_pop && !b1_valid) begin
        out_count <= out_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b1_valid) begin
      out_slots[out_wptr] <= b1_res;
    end
  end

endmodule

`default_nettype wire

/* sv/canonical_kmer_bucket_histogram.sv */
// An accepted transaction passes the front stage register, the internal queue, the back
// stage register and the result queue before its result is on the result ports.
// Throughput: one transaction per cycle while no queue is full and no clearing pass runs;
// the histogram read-modify-write with forwarding of the previous write sets that rate.
// Reset (synchronous, active high) clears the windows and starts a clearing pass over all 65536
// buckets of the histogram store, during which full stays high.
`default_nettype none

module canonical_kmer_bucket_histogram import ckbh_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire item_t              item,
  output logic                    full,
  output result_t                 result,
  output logic                    empty,
  input  wire logic               pop,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [LEN_W-1:0]     edge_len;
  logic [LEN_W-1:0]     len_eff;
  logic [REG_IDX_W-1:0] reg_idx;

  logic                 clearing;
  logic                 q_push;
  work_t                q_in;
  logic                 q_full;
  logic                 q_pop;
  work_t                q_out;
  logic                 q_empty;

  // Configuration register access.
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1 -: REG_IDX_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_len <= EDGE_LEN_RESET;
    end else if (psel && penable && pwrite && pready && reg_idx == REG_EDGE_LEN) begin
      edge_len <= pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_EDGE_LEN: prdata = {{(32 - LEN_W){1'b0}}, edge_len};
      default:      prdata = '0;
    endcase
  end

  // Clamp the edge length into the supported range.
  always_comb begin
    if (edge_len < LEN_W'(MIN_EDGE_LEN)) begin
      len_eff = LEN_W'(MIN_EDGE_LEN);
    end else if (edge_len > LEN_W'(MAX_EDGE_LEN)) begin
      len_eff = LEN_W'(MAX_EDGE_LEN);
    end else begin
      len_eff = edge_len;
    end
  end

  ckbh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .len_eff  (len_eff),
    .clearing (clearing),
    .q_push   (q_push),
    .q_entry  (q_in),
    .q_full   (q_full)
  );

  ckbh_mid_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .rd_entry (q_out),
    .empty    (q_empty)
  );

  ckbh_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_entry  (q_out),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .clearing (clearing),
    .result   (result),
    .empty    (empty),
    .pop      (pop)
  );

  // The front never writes into a full internal queue.
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("internal queue overflow");

  // No transaction is taken while the histogram is being cleared.
  assert property (@(posedge clk) disable iff (rst) clearing |-> full)
    else $error("input open during clearing pass");

  // The back only draws real entries, and only once clearing is over.
  assert property (@(posedge clk) disable iff (rst) q_pop |-> (!q_empty && !clearing))
    else $error("bad draw from internal queue");

endmodule

`default_nettype wire
